// ===== design/tsp_pkg.sv =====
// shared types and constants of the tone sequence parser
`default_nettype none

package tsp_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned DUR_W   = 26;
  localparam int unsigned VOL_W   = 7;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned TEMPO_W = 10;
  localparam int unsigned DEN_W   = 18;
  localparam int unsigned CNT_W   = $clog2(DUR_W);

  // milliseconds per whole note at one beat per minute, over four
  localparam logic [DEN_W-1:0] MS_SCALE = DEN_W'(240000);

  // reset values of the sequence state
  localparam logic [TEMPO_W-1:0] TEMPO_INIT = TEMPO_W'(120);
  localparam logic [BYTE_W-1:0]  RES_INIT   = BYTE_W'(64);
  localparam logic [BYTE_W-1:0]  VOL_INIT   = BYTE_W'(100);
  localparam logic [VOL_W-1:0]   VOL_MAX    = VOL_W'(100);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SEG  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TRUNC  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNITS  = 3'd2;
  localparam logic [ERR_W-1:0] ERR_CMD    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NONOTE = 3'd4;

  // command bytes
  localparam logic [BYTE_W-1:0] BYTE_SILENCE   = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_VERSION   = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_TEMPO     = 8'hFD;
  localparam logic [BYTE_W-1:0] BYTE_RES       = 8'hFC;
  localparam logic [BYTE_W-1:0] BYTE_BLK_START = 8'hFB;
  localparam logic [BYTE_W-1:0] BYTE_BLK_END   = 8'hFA;
  localparam logic [BYTE_W-1:0] BYTE_PLAY_BLK  = 8'hF9;
  localparam logic [BYTE_W-1:0] BYTE_VOLUME    = 8'hF8;
  localparam logic [BYTE_W-1:0] BYTE_REPEAT    = 8'hF7;

  // one result beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] note;
    logic [BYTE_W-1:0] count;
    logic [DUR_W-1:0]  dur;
    logic [VOL_W-1:0]  vol;
    logic [ERR_W-1:0]  err;
    logic              done;
  } res_t;

  // divider status toward the parser
  typedef struct packed {
    logic             done;
    logic [DUR_W-1:0] quo;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/tsp_ifs.sv =====
// channel interfaces of the tone sequence parser
`default_nettype none

interface tsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] seq_byte;
  logic       seq_last;
  modport source (output valid, output seq_byte, output seq_last, input ready);
  modport sink (input valid, input seq_byte, input seq_last, output ready);
endinterface

interface tsp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic signed [7:0] note;
  logic [7:0]        play_count;
  logic [25:0]       duration_ms;
  logic [6:0]        volume_level;
  logic [2:0]        error_code;
  logic              seq_done;
  modport source (output valid, output result_kind, output note, output play_count,
                  output duration_ms, output volume_level, output error_code,
                  output seq_done, input ready);
  modport sink (input valid, input result_kind, input note, input play_count,
                input duration_ms, input volume_level, input error_code,
                input seq_done, output ready);
endinterface

interface tsp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_volume;
  modport source (output valid, output base_volume, input ready);
  modport sink (input valid, input base_volume, output ready);
endinterface

`default_nettype wire

// ===== design/tsp_div.sv =====
// bit-serial restoring divider for segment durations
`default_nettype none

module tsp_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tsp_pkg::BYTE_W-1:0] units,
  input  wire logic [tsp_pkg::DEN_W-1:0]  den,
  output tsp_pkg::div_res_t               res
);
  import tsp_pkg::*;

  logic [DUR_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DUR_W-1:0] num;
  logic [DEN_W+1:0] diff;

  // dividend is units scaled by the constant
  assign num = DUR_W'(MS_SCALE) * DUR_W'(units);

  // one quotient bit per cycle
  always_comb begin
    diff    = {1'b0, rem_r, acc_r[DUR_W-1]} - {2'b00, den_r};
    acc_nxt = {acc_r[DUR_W-2:0], ~diff[DEN_W+1]};
    if (diff[DEN_W+1]) begin
      rem_nxt = {rem_r[DEN_W-2:0], acc_r[DUR_W-1]};
    end else begin
      rem_nxt = diff[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DUR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  // duration is at least one millisecond
  assign res.done = done_r;
  assign res.quo  = (acc_r == '0) ? DUR_W'(1) : acc_r;

endmodule

`default_nettype wire

// ===== design/tsp_oq.sv =====
// four-entry result queue driving the output channel
`default_nettype none

module tsp_oq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire tsp_pkg::res_t push_data,
  output logic [2:0]         level,
  tsp_out_if.source          out_ch
);
  import tsp_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       pop;
  res_t       head;

  assign pop   = out_ch.valid && out_ch.ready;
  assign level = cnt_r;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + {2'b00, push} - {2'b00, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // head beat on the output channel
  assign head                = mem[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.result_kind  = head.kind;
  assign out_ch.note         = $signed(head.note);
  assign out_ch.play_count   = head.count;
  assign out_ch.duration_ms  = head.dur;
  assign out_ch.volume_level = head.vol;
  assign out_ch.error_code   = head.err;
  assign out_ch.seq_done     = head.done;

endmodule

`default_nettype wire

// ===== design/tone_sequence_parser_top.sv =====
// top level of the tone sequence parser: byte parser, divider and result queue
//
// Usage:
//   in_ch takes one sequence byte per beat, seq_last set on the final byte.
//   out_ch gives segment, finished and error beats; seq_done closes a sequence.
//   cfg_ch writes base_volume, picked up at the first byte of the next
//   sequence; write it only while the block is idle.
// Timing and throughput:
//   command, argument and note bytes are taken without starting the divider.
//   a units byte that yields a segment runs the serial divider, one quotient
//   bit a cycle; the segment beat enters the queue when the divider is done
//   and a following finished beat in the cycle after, so such a byte holds
//   in_ch.ready low until the last of these beats has entered the queue.
//   results enter a four-entry queue; input is taken while the queue holds two
//   or fewer beats, so a stalled receiver blocks input only once it backs up.
// Reset: rst_n is synchronous; the queue empties, the parser returns to the
//   start of a sequence and base_volume becomes 100.
`default_nettype none

module tone_sequence_parser_top (
  input  wire logic clk,
  input  wire logic rst_n,
  tsp_in_if.sink    in_ch,
  tsp_out_if.source out_ch,
  tsp_cfg_if.sink   cfg_ch
);
  import tsp_pkg::*;

  typedef enum logic [2:0] {
    PH_START, PH_IDLE, PH_UNITS, PH_ARG, PH_RCOUNT, PH_RNOTE, PH_RUNITS
  } phase_t;

  typedef enum logic [1:0] {CMD_SKIP, CMD_TEMPO, CMD_RES, CMD_VOL} cmd_t;

  typedef enum logic [1:0] {CT_IDLE, CT_DIV, CT_FIN} ctl_t;

  // sequence state
  phase_t              phase_r, phase_nxt, ph_work;
  cmd_t                pend_r, pend_nxt;
  logic [BYTE_W-1:0]   note_r, note_nxt;
  logic [BYTE_W-1:0]   hcnt_r, hcnt_nxt;
  logic [TEMPO_W-1:0]  tempo_r, tempo_nxt;
  logic [BYTE_W-1:0]   res_r, res_nxt;
  logic [VOL_W-1:0]    vol_r, vol_nxt, vol_work;
  logic                any_r, any_nxt;
  logic                drop_r, drop_nxt;
  logic [BYTE_W-1:0]   dv_r;

  // segment held while the divider runs
  ctl_t                ct_r, ct_nxt;
  logic [BYTE_W-1:0]   seg_note_r, seg_note_nxt;
  logic [BYTE_W-1:0]   seg_cnt_r, seg_cnt_nxt;
  logic [VOL_W-1:0]    seg_vol_r;
  logic                fin_pend_r;

  logic                accept, seg, rst_seq, imm_push;
  logic [ERR_W-1:0]    err;
  logic [KIND_W-1:0]   imm_kind;
  logic [ERR_W-1:0]    imm_code;
  logic [BYTE_W-1:0]   b;
  logic                last;

  logic                push;
  res_t                push_data;
  logic [2:0]          level;
  logic [DEN_W-1:0]    tempo_w, res_w, div_den;
  div_res_t            div_res;

  function automatic logic [VOL_W-1:0] clamp100(input logic [BYTE_W-1:0] v);
    clamp100 = (v > BYTE_W'(VOL_MAX)) ? VOL_MAX : v[VOL_W-1:0];
  endfunction

  assign b      = in_ch.seq_byte;
  assign last   = in_ch.seq_last;
  assign in_ch.ready  = (ct_r == CT_IDLE) && (level <= 3'd2);
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // byte decode and sequence state update
  always_comb begin
    ph_work      = (phase_r == PH_START) ? PH_IDLE : phase_r;
    vol_work     = (phase_r == PH_START) ? clamp100(dv_r) : vol_r;
    phase_nxt    = ph_work;
    pend_nxt     = pend_r;
    note_nxt     = note_r;
    hcnt_nxt     = hcnt_r;
    tempo_nxt    = tempo_r;
    res_nxt      = res_r;
    vol_nxt      = vol_work;
    any_nxt      = any_r;
    drop_nxt     = drop_r;
    err          = ERR_NONE;
    seg          = 1'b0;
    seg_note_nxt = note_r;
    seg_cnt_nxt  = BYTE_W'(1);
    rst_seq      = 1'b0;
    imm_push     = 1'b0;
    imm_kind     = KIND_ERR;
    imm_code     = ERR_NONE;
    if (drop_r) begin
      rst_seq = last;
    end else begin
      case (ph_work)
        PH_IDLE: begin
          case (b) inside
            [8'h00:8'h7F], BYTE_SILENCE: begin
              note_nxt  = b;
              phase_nxt = PH_UNITS;
            end
            BYTE_VERSION, BYTE_BLK_START, BYTE_PLAY_BLK: begin
              pend_nxt  = CMD_SKIP;
              phase_nxt = PH_ARG;
            end
            BYTE_TEMPO: begin
              pend_nxt  = CMD_TEMPO;
              phase_nxt = PH_ARG;
            end
            BYTE_RES: begin
              pend_nxt  = CMD_RES;
              phase_nxt = PH_ARG;
            end
            BYTE_VOLUME: begin
              pend_nxt  = CMD_VOL;
              phase_nxt = PH_ARG;
            end
            BYTE_REPEAT: begin
              phase_nxt = PH_RCOUNT;
            end
            BYTE_BLK_END: begin
            end
            default: begin
              err = ERR_CMD;
            end
          endcase
        end
        PH_UNITS: begin
          if (b == '0) begin
            err = ERR_UNITS;
          end else begin
            seg          = 1'b1;
            seg_note_nxt = note_r;
            any_nxt      = 1'b1;
            phase_nxt    = PH_IDLE;
          end
        end
        PH_ARG: begin
          case (pend_r)
            CMD_TEMPO: tempo_nxt = (b == '0) ? TEMPO_W'(1) : {b, 2'b00};
            CMD_RES:   res_nxt   = (b == '0) ? BYTE_W'(1) : b;
            CMD_VOL:   vol_nxt   = clamp100(b);
            default:   vol_nxt   = vol_work;
          endcase
          phase_nxt = PH_IDLE;
        end
        PH_RCOUNT: begin
          hcnt_nxt  = b;
          phase_nxt = PH_RNOTE;
        end
        PH_RNOTE: begin
          note_nxt  = b;
          phase_nxt = PH_RUNITS;
        end
        PH_RUNITS: begin
          if (b == '0) begin
            err = ERR_UNITS;
          end else begin
            if (hcnt_r != '0) begin
              seg          = 1'b1;
              seg_note_nxt = note_r;
              seg_cnt_nxt  = hcnt_r;
              any_nxt      = 1'b1;
            end
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // closing beat of the sequence
      if (err != ERR_NONE) begin
        imm_push = 1'b1;
        imm_code = err;
        rst_seq  = last;
        drop_nxt = !last;
      end else if (last) begin
        rst_seq  = 1'b1;
        imm_push = !seg;
        if (phase_nxt != PH_IDLE) begin
          imm_code = ERR_TRUNC;
        end else if (any_nxt) begin
          imm_kind = KIND_FIN;
        end else begin
          imm_code = ERR_NONOTE;
        end
      end
    end
  end

  // control sequencer next state
  always_comb begin
    ct_nxt = ct_r;
    unique case (ct_r)
      CT_IDLE: if (accept && seg) ct_nxt = CT_DIV;
      CT_DIV:  if (div_res.done) ct_nxt = fin_pend_r ? CT_FIN : CT_IDLE;
      CT_FIN:  ct_nxt = CT_IDLE;
      default: ct_nxt = CT_IDLE;
    endcase
  end

  // state and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      pend_r     <= CMD_SKIP;
      note_r     <= '0;
      hcnt_r     <= '0;
      tempo_r    <= TEMPO_INIT;
      res_r      <= RES_INIT;
      vol_r      <= VOL_MAX;
      any_r      <= 1'b0;
      drop_r     <= 1'b0;
      dv_r       <= VOL_INIT;
      ct_r       <= CT_IDLE;
      fin_pend_r <= 1'b0;
    end else begin
      ct_r <= ct_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        dv_r <= cfg_ch.base_volume;
      end
      if (accept) begin
        if (rst_seq) begin
          phase_r <= PH_START;
          pend_r  <= CMD_SKIP;
          note_r  <= '0;
          hcnt_r  <= '0;
          tempo_r <= TEMPO_INIT;
          res_r   <= RES_INIT;
          vol_r   <= clamp100(dv_r);
          any_r   <= 1'b0;
          drop_r  <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          pend_r  <= pend_nxt;
          note_r  <= note_nxt;
          hcnt_r  <= hcnt_nxt;
          tempo_r <= tempo_nxt;
          res_r   <= res_nxt;
          vol_r   <= vol_nxt;
          any_r   <= any_nxt;
          drop_r  <= drop_nxt;
        end
        if (seg) begin
          fin_pend_r <= last;
        end
      end
    end
  end

  // segment fields kept for the divider's finish
  always_ff @(posedge clk) begin
    if (accept && seg) begin
      seg_note_r <= seg_note_nxt;
      seg_cnt_r  <= seg_cnt_nxt;
      seg_vol_r  <= vol_work;
    end
  end

  // tempo times resolution feeds the divider
  assign tempo_w = DEN_W'(tempo_r);
  assign res_w   = DEN_W'(res_r);
  assign div_den = tempo_w * res_w;

  tsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && seg),
    .units (b),
    .den   (div_den),
    .res   (div_res)
  );

  // queue writes: immediate closing beats, segments, trailing finished beat
  always_comb begin
    push           = 1'b0;
    push_data      = '0;
    push_data.kind = KIND_ERR;
    if (ct_r == CT_DIV) begin
      push            = div_res.done;
      push_data.kind  = KIND_SEG;
      push_data.note  = seg_note_r;
      push_data.count = seg_cnt_r;
      push_data.dur   = div_res.quo;
      push_data.vol   = seg_vol_r;
    end else if (ct_r == CT_FIN) begin
      push           = 1'b1;
      push_data.kind = KIND_FIN;
      push_data.done = 1'b1;
    end else begin
      push           = accept && imm_push;
      push_data.kind = imm_kind;
      push_data.err  = imm_code;
      push_data.done = 1'b1;
    end
  end

  tsp_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .level     (level),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/tsp_check.sv =====
// port checker for the tone sequence parser and its bind
`default_nettype none

module tsp_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic [25:0] out_dur,
  input wire logic [2:0]  out_err,
  input wire logic        out_done
);
  import tsp_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_dur)
      && $stable(out_err) && $stable(out_done))
    else $error("result beat changed while stalled");

  // segments carry a duration and never close a sequence
  a_seg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEG |-> out_dur != '0 && !out_done
      && out_err == ERR_NONE)
    else $error("bad segment beat");

  // error beats carry a code and close the sequence
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_err != ERR_NONE && out_done)
    else $error("bad error beat");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result beat after reset");

endmodule

bind tone_sequence_parser_top tsp_check u_tsp_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_dur   (out_ch.duration_ms),
  .out_err   (out_ch.error_code),
  .out_done  (out_ch.seq_done)
);

`default_nettype wire

// ===== dv/tb_tone_sequence_parser_top.sv =====
// testbench of the tone sequence parser: byte stimulus, result prediction and checks
`timescale 1ns / 100ps

module tb_tone_sequence_parser_top;
  import tsp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned IDLE_PCT    = 26;

  typedef enum logic [2:0] {
    SEQ_START, SEQ_IDLE, WAIT_UNITS, WAIT_ARG, WAIT_RCOUNT, WAIT_RNOTE, WAIT_RUNITS
  } parse_at_t;

  typedef enum logic [1:0] {ARG_SKIP, ARG_TEMPO, ARG_RES, ARG_VOL} arg_kind_t;

  // predicts the result beats of each accepted byte and checks the received ones
  class tone_scoreboard;
    res_t        awaited_beats[$];
    int unsigned fail_count;
    logic [7:0]  dflt_volume;
    parse_at_t   parse_at;
    arg_kind_t   arg_kind;
    logic [7:0]  note_hold;
    logic [7:0]  count_hold;
    logic [9:0]  tempo;
    logic [7:0]  resolution;
    logic [6:0]  volume;
    bit          played;
    bit          draining;

    function new();
      fail_count  = 0;
      dflt_volume = VOL_INIT;
      restart();
    endfunction

    function logic [6:0] cap_volume(logic [7:0] v);
      return (v > VOL_MAX) ? VOL_MAX : v[6:0];
    endfunction

    function void restart();
      parse_at   = SEQ_START;
      arg_kind   = ARG_SKIP;
      note_hold  = '0;
      count_hold = '0;
      tempo      = TEMPO_INIT;
      resolution = RES_INIT;
      volume     = cap_volume(dflt_volume);
      played     = 1'b0;
      draining   = 1'b0;
    endfunction

    function void set_base_volume(logic [7:0] v);
      dflt_volume = v;
    endfunction

    // whole-note scale times units over tempo times resolution, at least 1 ms
    function logic [25:0] span_ms(logic [7:0] units);
      longint unsigned den;
      longint unsigned q;
      den = longint'(tempo) * longint'(resolution);
      q   = longint'(MS_SCALE) * longint'(units) / den;
      return (q == 0) ? 26'd1 : q[25:0];
    endfunction

    function void add_segment(logic [7:0] count, logic [7:0] units);
      res_t r;
      r.kind  = KIND_SEG;
      r.note  = note_hold;
      r.count = count;
      r.dur   = span_ms(units);
      r.vol   = volume;
      r.err   = ERR_NONE;
      r.done  = 1'b0;
      awaited_beats = {awaited_beats, r};
      played = 1'b1;
    endfunction

    function void add_close(logic [1:0] kind, logic [2:0] code);
      res_t r;
      r      = '0;
      r.kind = kind;
      r.err  = code;
      r.done = 1'b1;
      awaited_beats = {awaited_beats, r};
    endfunction

    // one accepted input beat
    function void parse_byte(logic [7:0] b, logic is_last);
      logic [2:0] fault;
      fault = ERR_NONE;
      // rest of a broken sequence is swallowed
      if (draining) begin
        if (is_last) restart();
        return;
      end
      if (parse_at == SEQ_START) begin
        tempo      = TEMPO_INIT;
        resolution = RES_INIT;
        volume     = cap_volume(dflt_volume);
        parse_at   = SEQ_IDLE;
      end
      case (parse_at)
        SEQ_IDLE: begin
          if (b < 8'h80 || b == BYTE_SILENCE) begin
            note_hold = b;
            parse_at  = WAIT_UNITS;
          end else if (b == BYTE_VERSION || b == BYTE_BLK_START || b == BYTE_PLAY_BLK) begin
            arg_kind = ARG_SKIP;
            parse_at = WAIT_ARG;
          end else if (b == BYTE_TEMPO) begin
            arg_kind = ARG_TEMPO;
            parse_at = WAIT_ARG;
          end else if (b == BYTE_RES) begin
            arg_kind = ARG_RES;
            parse_at = WAIT_ARG;
          end else if (b == BYTE_VOLUME) begin
            arg_kind = ARG_VOL;
            parse_at = WAIT_ARG;
          end else if (b == BYTE_REPEAT) begin
            parse_at = WAIT_RCOUNT;
          end else if (b != BYTE_BLK_END) begin
            fault = ERR_CMD;
          end
        end
        WAIT_UNITS: begin
          if (b == 8'd0) begin
            fault = ERR_UNITS;
          end else begin
            add_segment(8'd1, b);
            parse_at = SEQ_IDLE;
          end
        end
        WAIT_ARG: begin
          case (arg_kind)
            ARG_TEMPO: tempo      = (b == 8'd0) ? 10'd1 : {b, 2'b00};
            ARG_RES:   resolution = (b == 8'd0) ? 8'd1 : b;
            ARG_VOL:   volume     = cap_volume(b);
            default: ;
          endcase
          parse_at = SEQ_IDLE;
        end
        WAIT_RCOUNT: begin
          count_hold = b;
          parse_at   = WAIT_RNOTE;
        end
        WAIT_RNOTE: begin
          note_hold = b;
          parse_at  = WAIT_RUNITS;
        end
        WAIT_RUNITS: begin
          if (b == 8'd0) begin
            fault = ERR_UNITS;
          end else begin
            // a zero count plays nothing and does not count as a note
            if (count_hold != 8'd0) add_segment(count_hold, b);
            parse_at = SEQ_IDLE;
          end
        end
        default: parse_at = SEQ_IDLE;
      endcase
      if (fault != ERR_NONE) begin
        add_close(KIND_ERR, fault);
        if (is_last) restart();
        else draining = 1'b1;
        return;
      end
      // closing beat of the sequence
      if (is_last) begin
        if (parse_at != SEQ_IDLE) add_close(KIND_ERR, ERR_TRUNC);
        else if (played) add_close(KIND_FIN, ERR_NONE);
        else add_close(KIND_ERR, ERR_NONOTE);
        restart();
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    // one accepted result beat against the oldest prediction
    function void check_beat(res_t got);
      res_t want;
      if (awaited_beats.size() == 0) begin
        $display("%0t: result beat with none expected, expected nothing, actual %p",
                 $time, got);
        fail_count++;
        return;
      end
      want = awaited_beats.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("note", want.note, got.note);
      compare_field("play_count", want.count, got.count);
      compare_field("duration_ms", want.dur, got.dur);
      compare_field("volume_level", want.vol, got.vol);
      compare_field("error_code", want.err, got.err);
      compare_field("seq_done", want.done, got.done);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tsp_in_if  in_ch();
  tsp_out_if out_ch();
  tsp_cfg_if cfg_ch();

  tone_scoreboard board;
  logic [7:0]     tone_bytes[$];
  bit             in_idle_on;
  bit             out_idle_on;
  int unsigned    quiet_cycles = 0;

  tone_sequence_parser_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result receiver with random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= out_idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // monitor of all three channels, plus the count of quiet cycles
  always @(posedge clk) begin
    res_t beat;
    bit   moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        board.set_base_volume(cfg_ch.base_volume);
        moved = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        board.parse_byte(in_ch.seq_byte, in_ch.seq_last);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        beat.kind  = out_ch.result_kind;
        beat.note  = out_ch.note;
        beat.count = out_ch.play_count;
        beat.dur   = out_ch.duration_ms;
        beat.vol   = out_ch.volume_level;
        beat.err   = out_ch.error_code;
        beat.done  = out_ch.seq_done;
        board.check_beat(beat);
        moved = 1'b1;
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.seq_byte <= b;
    in_ch.seq_last <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_sequence();
    foreach (tone_bytes[i]) send_byte(tone_bytes[i], i == tone_bytes.size() - 1);
  endtask

  task automatic write_volume(input logic [7:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.base_volume <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // drain all expected beats, then give the divider time to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.awaited_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // append one byte to the sequence under construction
  function automatic void add_byte(logic [7:0] v);
    tone_bytes = {tone_bytes, v};
  endfunction

  // short units are common so that the one-millisecond floor shows up
  function automatic logic [7:0] pick_units();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
  endfunction

  // random sequence: mostly well formed, some noise and broken endings
  function automatic void compose_sequence();
    int unsigned pick;
    tone_bytes.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        add_byte(($urandom_range(4) == 0) ? BYTE_SILENCE : 8'($urandom_range(0, 127)));
        add_byte(pick_units());
      end else if (pick < 50) begin
        add_byte(BYTE_TEMPO);
        add_byte(8'($urandom));
      end else if (pick < 58) begin
        add_byte(BYTE_RES);
        add_byte(8'($urandom));
      end else if (pick < 66) begin
        add_byte(BYTE_VOLUME);
        add_byte(8'($urandom));
      end else if (pick < 74) begin
        case ($urandom_range(2))
          0: add_byte(BYTE_VERSION);
          1: add_byte(BYTE_BLK_START);
          default: add_byte(BYTE_PLAY_BLK);
        endcase
        add_byte(8'($urandom));
      end else if (pick < 78) begin
        add_byte(BYTE_BLK_END);
      end else begin
        add_byte(BYTE_REPEAT);
        add_byte(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom));
        add_byte(8'($urandom));
        add_byte(pick_units());
      end
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      // zero units, then some bytes that must be ignored
      add_byte(8'($urandom_range(0, 127)));
      add_byte(8'd0);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end else if (pick < 8) begin
      // command byte with no meaning
      add_byte(8'($urandom_range(8'h80, 8'hF6)));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end else if (pick < 12 && tone_bytes.size() > 1) begin
      // cut short
      void'(tone_bytes.pop_back());
    end
  endfunction

  // main sequence
  initial begin
    logic [7:0]  settings[5];
    int unsigned sent;
    in_ch.valid        <= 1'b0;
    in_ch.seq_byte     <= '0;
    in_ch.seq_last     <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.base_volume <= '0;
    rst_n              <= 1'b0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: tempo and resolution of zero, silence, longest duration, two results
    tone_bytes = {BYTE_TEMPO, 8'h00, BYTE_RES, 8'h00, BYTE_SILENCE, 8'hFF};
    send_sequence();
    // fastest tempo and finest resolution, clamped volume, repeat of a negative note
    tone_bytes = {BYTE_TEMPO, 8'hFF, BYTE_RES, 8'hFF, BYTE_VOLUME, 8'hC8,
                  BYTE_REPEAT, 8'h05, 8'h80, 8'h01, BYTE_BLK_END};
    send_sequence();
    // skipped arguments and a zero repeat count leave no playable note
    tone_bytes = {BYTE_VERSION, 8'h00, BYTE_BLK_START, 8'h01, BYTE_PLAY_BLK, 8'h02,
                  BYTE_REPEAT, 8'h00, 8'h7F, 8'h40};
    send_sequence();
    // zero units mid sequence, the rest is dropped
    tone_bytes = {8'h00, 8'h00, 8'h7F};
    send_sequence();
    // unknown command on the last byte
    tone_bytes = {8'hF6};
    send_sequence();
    // repeat cut short
    tone_bytes = {BYTE_REPEAT, 8'h03};
    send_sequence();
    settle();

    // random phases, each under its own base volume
    settings[0] = 8'd0;
    settings[1] = 8'd255;
    settings[2] = 8'd101;
    settings[3] = 8'd100;
    settings[4] = 8'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_volume(settings[p]);
      in_idle_on  = (p != 2);
      out_idle_on = (p != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        compose_sequence();
        send_sequence();
        sent += tone_bytes.size();
      end
      settle();
    end

    if (board.fail_count == 0 && board.awaited_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tsp_pkg.sv
design/tsp_ifs.sv
design/tsp_div.sv
design/tsp_oq.sv
design/tone_sequence_parser_top.sv
design/tsp_check.sv
dv/tb_tone_sequence_parser_top.sv
